FILE: rtl/crc8wfc_pkg.sv
package crc8wfc_pkg;

    // CRC-8 constants: polynomial x^8 + x^5 + x^4 + 1, MSB first, no final XOR.
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // Structural limits.
    localparam int MAX_WORDS_DEFAULT = 8;
    localparam int INDEX_LIMIT       = 8;

    // Register map.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_WORDS_PER_FRAME = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_ENABLE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_LIMIT     = 2'd2;

    // Register reset values.
    localparam logic [3:0]  WORDS_PER_FRAME_RST = 4'd3;
    localparam logic        CHECK_ENABLE_RST    = 1'b1;
    localparam logic [15:0] FIRST_LIMIT_RST     = 16'd40000;

    // Frame status codes.
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_CRC  = 2'd1,
        STATUS_ZERO = 2'd2,
        STATUS_HIGH = 2'd3
    } status_t;

    // Position of the next byte within its three-byte group.
    typedef enum logic [2:0] {
        PH_HIGH = 3'b001,
        PH_LOW  = 3'b010,
        PH_CRC  = 3'b100
    } phase_t;

    // Configuration as seen by the frame engine.
    typedef struct packed {
        logic [3:0]  words_per_frame;
        logic        check_enable;
        logic [15:0] first_limit;
    } cfg_t;

    // One byte of CRC update, eight shift steps.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/crc8wfc_if.sv
// Byte request channel.
interface crc8wfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// Word result channel.
interface crc8wfc_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] word_value;
    logic [2:0]  word_index;
    logic        word_crc_ok;
    logic        frame_last;
    logic [1:0]  frame_status;

    modport source (output valid, output word_value, output word_index, output word_crc_ok,
                    output frame_last, output frame_status, input ready);
    modport sink   (input valid, input word_value, input word_index, input word_crc_ok,
                    input frame_last, input frame_status, output ready);
endinterface

FILE: rtl/crc8wfc_cfg_regs.sv
module crc8wfc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [crc8wfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crc8wfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output crc8wfc_pkg::cfg_t                   cfg
);

    crc8wfc_pkg::cfg_t cfg_reg;
    crc8wfc_pkg::cfg_t cfg_next;

    // Decode the write; an index beyond the map is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                crc8wfc_pkg::REG_WORDS_PER_FRAME: cfg_next.words_per_frame = cfg_data[3:0];
                crc8wfc_pkg::REG_CHECK_ENABLE:    cfg_next.check_enable    = cfg_data[0];
                crc8wfc_pkg::REG_FIRST_LIMIT:     cfg_next.first_limit     = cfg_data[15:0];
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.words_per_frame <= crc8wfc_pkg::WORDS_PER_FRAME_RST;
            cfg_reg.check_enable    <= crc8wfc_pkg::CHECK_ENABLE_RST;
            cfg_reg.first_limit     <= crc8wfc_pkg::FIRST_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/crc8wfc_engine.sv
module crc8wfc_engine #(
    parameter int MAX_WORDS = crc8wfc_pkg::MAX_WORDS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  crc8wfc_pkg::cfg_t     cfg,
    crc8wfc_byte_if.sink          byte_in,
    crc8wfc_word_if.source        word_out
);

    // Effective frame length bound: the word index reaches at most eight words.
    localparam int          CAP_INT = (MAX_WORDS > crc8wfc_pkg::INDEX_LIMIT)
                                      ? crc8wfc_pkg::INDEX_LIMIT
                                      : ((MAX_WORDS < 1) ? 1 : MAX_WORDS);
    localparam logic [3:0]  LEN_CAP = 4'(CAP_INT);

    // Frame state.
    crc8wfc_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]           crc_reg, crc_next;
    logic [7:0]           high_reg, high_next;
    logic [7:0]           low_reg, low_next;
    logic [2:0]           words_seen_reg, words_seen_next;
    logic                 crc_fail_reg, crc_fail_next;
    crc8wfc_pkg::status_t fault_reg, fault_next;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          out_word_reg, out_word_next;
    logic [2:0]           out_index_reg, out_index_next;
    logic                 out_ok_reg, out_ok_next;
    logic                 out_last_reg, out_last_next;
    crc8wfc_pkg::status_t out_status_reg, out_status_next;

    logic                 accept;
    logic                 load_result;
    crc8wfc_pkg::phase_t  phase_eff;
    logic [3:0]           frame_len;
    logic [15:0]          word;
    logic                 crc_ok;
    logic                 is_last;
    logic                 fail_now;
    crc8wfc_pkg::status_t fault_now;

    // A new byte is taken whenever the result register is free or being drained.
    assign byte_in.ready = !out_valid_reg || word_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;

    // Frame length clamped to the range 1 .. cap.
    always_comb
    begin
        frame_len = (cfg.words_per_frame == 4'd0) ? 4'd1 : cfg.words_per_frame;
        if (frame_len > LEN_CAP)
        begin
            frame_len = LEN_CAP;
        end
    end

    // Word assembly, CRC compare and frame status for the CRC byte of a group.
    always_comb
    begin
        word     = {high_reg, low_reg};
        crc_ok   = (crc_reg == byte_in.rx_byte);
        fail_now = crc_fail_reg || !crc_ok;
        fault_now = fault_reg;
        if (words_seen_reg == 3'd0 && cfg.check_enable)
        begin
            if (word == 16'd0)
            begin
                fault_now = crc8wfc_pkg::STATUS_ZERO;
            end
            else if (word > cfg.first_limit)
            begin
                fault_now = crc8wfc_pkg::STATUS_HIGH;
            end
        end
        is_last = ({1'b0, words_seen_reg} + 4'd1) >= frame_len;
    end

    // Frame start discards any partial group.
    assign phase_eff = byte_in.frame_start ? crc8wfc_pkg::PH_HIGH : phase_reg;

    // Next frame state and result load.
    always_comb
    begin
        phase_next      = phase_reg;
        crc_next        = crc_reg;
        high_next       = high_reg;
        low_next        = low_reg;
        words_seen_next = words_seen_reg;
        crc_fail_next   = crc_fail_reg;
        fault_next      = fault_reg;
        load_result     = 1'b0;
        if (accept)
        begin
            if (byte_in.frame_start)
            begin
                words_seen_next = 3'd0;
                crc_fail_next   = 1'b0;
                fault_next      = crc8wfc_pkg::STATUS_OK;
            end
            case (phase_eff)
                crc8wfc_pkg::PH_LOW:
                begin
                    low_next   = byte_in.rx_byte;
                    crc_next   = crc8wfc_pkg::crc_byte(crc_reg, byte_in.rx_byte);
                    phase_next = crc8wfc_pkg::PH_CRC;
                end
                crc8wfc_pkg::PH_CRC:
                begin
                    load_result = 1'b1;
                    phase_next  = crc8wfc_pkg::PH_HIGH;
                    crc_next    = crc8wfc_pkg::CRC_INIT;
                    if (is_last)
                    begin
                        words_seen_next = 3'd0;
                        crc_fail_next   = 1'b0;
                        fault_next      = crc8wfc_pkg::STATUS_OK;
                    end
                    else
                    begin
                        words_seen_next = words_seen_reg + 3'd1;
                        crc_fail_next   = fail_now;
                        fault_next      = fault_now;
                    end
                end
                default:
                begin
                    high_next  = byte_in.rx_byte;
                    crc_next   = crc8wfc_pkg::crc_byte(crc8wfc_pkg::CRC_INIT, byte_in.rx_byte);
                    phase_next = crc8wfc_pkg::PH_LOW;
                end
            endcase
        end
    end

    // Result register contents.
    always_comb
    begin
        out_valid_next  = out_valid_reg && !word_out.ready;
        out_word_next   = out_word_reg;
        out_index_next  = out_index_reg;
        out_ok_next     = out_ok_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        if (load_result)
        begin
            out_valid_next  = 1'b1;
            out_word_next   = word;
            out_index_next  = words_seen_reg;
            out_ok_next     = crc_ok;
            out_last_next   = is_last;
            out_status_next = crc8wfc_pkg::STATUS_OK;
            if (is_last)
            begin
                out_status_next = fail_now ? crc8wfc_pkg::STATUS_CRC : fault_now;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= crc8wfc_pkg::PH_HIGH;
            crc_reg        <= crc8wfc_pkg::CRC_INIT;
            words_seen_reg <= 3'd0;
            crc_fail_reg   <= 1'b0;
            fault_reg      <= crc8wfc_pkg::STATUS_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            crc_reg        <= crc_next;
            words_seen_reg <= words_seen_next;
            crc_fail_reg   <= crc_fail_next;
            fault_reg      <= fault_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        high_reg       <= high_next;
        low_reg        <= low_next;
        out_word_reg   <= out_word_next;
        out_index_reg  <= out_index_next;
        out_ok_reg     <= out_ok_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign word_out.valid        = out_valid_reg;
    assign word_out.word_value   = out_word_reg;
    assign word_out.word_index   = out_index_reg;
    assign word_out.word_crc_ok  = out_ok_reg;
    assign word_out.frame_last   = out_last_reg;
    assign word_out.frame_status = out_status_reg;

endmodule

FILE: rtl/crc8_word_frame_checker.sv
// Checks sensor response frames made of three-byte groups: high byte, low byte and a
// CRC-8 (polynomial 0x31, seed 0xFF) over the two.
// Bytes come in on byte_in, one request per byte; frame_start marks the first byte of
// a frame and drops any partial group. The CRC byte of each group produces one result
// request on word_out: the 16-bit word, its index, the CRC match and, on the last word
// of the frame, the frame status (CRC error first, then the first-word zero or limit
// fault). The other two bytes of a group produce no result.
// One byte is taken every cycle while word_out keeps up. A result appears on word_out
// in the cycle after its CRC byte is taken, from the single result register.
// When word_out stalls, the held result blocks byte_in until it drains; byte_in is
// ready again in the cycle in which word_out takes the held result. Configuration is
// written through cfg_write_en, cfg_index and cfg_data; the user must write it only
// while idle, the block does not enforce this. Reset clears the frame state and loads
// the register defaults: three words per frame, first-word check on, limit 40000.
module crc8_word_frame_checker #(
    parameter int MAX_WORDS = crc8wfc_pkg::MAX_WORDS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [crc8wfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crc8wfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    crc8wfc_byte_if.sink                        byte_in,
    crc8wfc_word_if.source                      word_out
);

    crc8wfc_pkg::cfg_t cfg;

    // Configuration registers.
    crc8wfc_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // Group assembly, CRC check and result register.
    crc8wfc_engine #(
        .MAX_WORDS (MAX_WORDS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .byte_in  (byte_in),
        .word_out (word_out)
    );

endmodule

FILE: test/crc8wfc_word_checker.sv
`timescale 1ns / 1ps

// Watches the byte and word channels of the frame checker, predicts every word
// result from the accepted byte requests and compares the results in order.
module crc8wfc_word_checker #(
    parameter int MAX_WORDS = crc8wfc_pkg::MAX_WORDS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [crc8wfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crc8wfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    crc8wfc_byte_if                             byte_in,
    crc8wfc_word_if                             word_out,
    output int                                  errors,
    output int                                  pending
);

    // Position of the next byte within its group.
    localparam logic [1:0] AT_HIGH = 2'd0;
    localparam logic [1:0] AT_LOW  = 2'd1;
    localparam logic [1:0] AT_CRC  = 2'd2;

    typedef struct {
        logic [15:0]          value;
        logic [2:0]           index;
        logic                 crc_ok;
        logic                 last;
        crc8wfc_pkg::status_t status;
    } word_result_t;

    // Predicted frame state.
    logic [1:0]           phase_q;
    logic [7:0]           crc_q;
    logic [7:0]           high_q;
    logic [7:0]           low_q;
    logic [2:0]           word_cnt;
    logic                 crc_bad;
    crc8wfc_pkg::status_t first_fault;

    // Shadow copy of the configuration registers.
    logic [3:0]  cfg_words;
    logic        cfg_check;
    logic [15:0] cfg_limit;

    word_result_t expected_words[$];
    word_result_t want;

    initial errors = 0;

    // Serial CRC-8 update, one data bit per step, most significant bit first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[7] ^ data[i];
            r = {r[6:0], 1'b0};
            if (fb)
            begin
                r = r ^ crc8wfc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // Effective frame length after clamping the register to the legal range.
    function automatic int frame_words();
        int n;
        int cap;
        n = cfg_words;
        cap = (MAX_WORDS > crc8wfc_pkg::INDEX_LIMIT) ? crc8wfc_pkg::INDEX_LIMIT : MAX_WORDS;
        if (cap < 1)
        begin
            cap = 1;
        end
        if (n < 1)
        begin
            n = 1;
        end
        if (n > cap)
        begin
            n = cap;
        end
        return n;
    endfunction

    task automatic clear_frame();
        phase_q = AT_HIGH;
        crc_q = crc8wfc_pkg::CRC_INIT;
        word_cnt = '0;
        crc_bad = 1'b0;
        first_fault = crc8wfc_pkg::STATUS_OK;
    endtask

    // Advances the predicted state by one byte; the CRC byte of a group yields a word.
    task automatic decode_byte(input logic [7:0] b, input logic fs);
        word_result_t res;
        logic [15:0]  word;
        if (fs)
        begin
            clear_frame();
        end
        if (phase_q == AT_LOW)
        begin
            low_q = b;
            crc_q = crc8_update(crc_q, b);
            phase_q = AT_CRC;
        end
        else if (phase_q != AT_CRC)
        begin
            high_q = b;
            crc_q = crc8_update(crc8wfc_pkg::CRC_INIT, b);
            phase_q = AT_LOW;
        end
        else
        begin
            word = {high_q, low_q};
            res.value = word;
            res.index = word_cnt;
            res.crc_ok = (crc_q == b);
            if (!res.crc_ok)
            begin
                crc_bad = 1'b1;
            end
            // The gas reading checks only apply to the first word of a frame.
            if (word_cnt == 3'd0 && cfg_check)
            begin
                if (word == 16'd0)
                begin
                    first_fault = crc8wfc_pkg::STATUS_ZERO;
                end
                else if (word > cfg_limit)
                begin
                    first_fault = crc8wfc_pkg::STATUS_HIGH;
                end
            end
            res.last = (int'(word_cnt) + 1 >= frame_words());
            res.status = !res.last ? crc8wfc_pkg::STATUS_OK
                                   : (crc_bad ? crc8wfc_pkg::STATUS_CRC : first_fault);
            expected_words.push_back(res);
            if (res.last)
            begin
                clear_frame();
            end
            else
            begin
                word_cnt = word_cnt + 3'd1;
                phase_q = AT_HIGH;
                crc_q = crc8wfc_pkg::CRC_INIT;
            end
        end
    endtask

    task automatic report(input string what, input logic [15:0] exp_val,
                          input logic [15:0] got_val);
        $display("%0t ns: word mismatch on %s: expected %0h, got %0h",
                 $realtime, what, exp_val, got_val);
        errors++;
    endtask

    // Compare finished word requests, track register writes and decode accepted byte requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            high_q = '0;
            low_q = '0;
            cfg_words = crc8wfc_pkg::WORDS_PER_FRAME_RST;
            cfg_check = crc8wfc_pkg::CHECK_ENABLE_RST;
            cfg_limit = crc8wfc_pkg::FIRST_LIMIT_RST;
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            if (word_out.valid && word_out.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    report("unexpected word", 16'd0, word_out.word_value);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (word_out.word_value !== want.value)
                    begin
                        report("word_value", want.value, word_out.word_value);
                    end
                    if (word_out.word_index !== want.index)
                    begin
                        report("word_index", 16'(want.index), 16'(word_out.word_index));
                    end
                    if (word_out.word_crc_ok !== want.crc_ok)
                    begin
                        report("word_crc_ok", 16'(want.crc_ok), 16'(word_out.word_crc_ok));
                    end
                    if (word_out.frame_last !== want.last)
                    begin
                        report("frame_last", 16'(want.last), 16'(word_out.frame_last));
                    end
                    if (word_out.frame_status !== want.status)
                    begin
                        report("frame_status", 16'(want.status), 16'(word_out.frame_status));
                    end
                end
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    crc8wfc_pkg::REG_WORDS_PER_FRAME: cfg_words = cfg_data[3:0];
                    crc8wfc_pkg::REG_CHECK_ENABLE:    cfg_check = cfg_data[0];
                    crc8wfc_pkg::REG_FIRST_LIMIT:     cfg_limit = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (byte_in.valid && byte_in.ready)
            begin
                decode_byte(byte_in.rx_byte, byte_in.frame_start);
            end
            pending <= expected_words.size();
        end
    end

endmodule

FILE: test/crc8_word_frame_checker_test.sv
`timescale 1ns / 1ps

// Drives byte requests into the frame checker: a short directed set of frames, then
// random configurations with mostly well-formed frames mixed with noise and cut frames.
module crc8_word_frame_checker_test;

    localparam int BYTE_TARGET = 1860;

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                cfg_write_en;
    logic [crc8wfc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [crc8wfc_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                                  errors;
    int                                  pending;
    int                                  bytes_sent = 0;
    bit                                  src_burst = 1'b0;
    bit                                  sink_burst = 1'b0;

    crc8wfc_byte_if byte_ch ();
    crc8wfc_word_if word_ch ();

    crc8_word_frame_checker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_in      (byte_ch),
        .word_out     (word_ch)
    );

    crc8wfc_word_checker word_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_in      (byte_ch),
        .word_out     (word_ch),
        .errors       (errors),
        .pending      (pending)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls before each word request, with bursts of none.
    initial
    begin
        int stall;
        word_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                sink_burst = !sink_burst;
            end
            stall = sink_burst ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                word_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            word_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!word_ch.valid);
        end
    end

    // One byte request after a random gap; valid stays high when the next has no gap.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        int gap;
        if ($urandom_range(0, 59) == 0)
        begin
            src_burst = !src_burst;
        end
        gap = src_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.rx_byte <= b;
        byte_ch.frame_start <= fs;
        do
        begin
            @(posedge clk);
        end
        while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // High byte, low byte and CRC; a bad CRC is flipped in at least one bit.
    task automatic send_word(input logic [15:0] value, input logic fs, input logic bad_crc);
        logic [7:0] crc;
        crc = crc8wfc_pkg::crc_byte(crc8wfc_pkg::crc_byte(crc8wfc_pkg::CRC_INIT, value[15:8]),
                                    value[7:0]);
        if (bad_crc)
        begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        send_byte(value[15:8], fs);
        send_byte(value[7:0], 1'b0);
        send_byte(crc, 1'b0);
    endtask

    // Writes all three registers in back-to-back cycles with the enable held high.
    task automatic write_config(input logic [3:0] words, input logic check,
                                input logic [15:0] limit);
        cfg_write_en <= 1'b1;
        cfg_index <= crc8wfc_pkg::REG_WORDS_PER_FRAME;
        cfg_data <= {{(crc8wfc_pkg::CFG_DATA_W-4){1'b0}}, words};
        @(posedge clk);
        cfg_index <= crc8wfc_pkg::REG_CHECK_ENABLE;
        cfg_data <= {{(crc8wfc_pkg::CFG_DATA_W-1){1'b0}}, check};
        @(posedge clk);
        cfg_index <= crc8wfc_pkg::REG_FIRST_LIMIT;
        cfg_data <= limit;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Stops the byte requests and waits until every predicted word has come out.
    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // First-word values that sit on the edges of the gas reading checks.
    function automatic logic [15:0] pick_first(input logic [15:0] limit);
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return limit;
            2: return limit + 16'd1;
            3: return 16'hFFFF;
            4: return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // Stimulus and verdict.
    initial
    begin
        logic [3:0]  words;
        logic        check;
        logic [15:0] limit;
        int          frame_len;
        int          phase_end;
        int          cut;
        logic        need_start;

        rst_n <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index <= crc8wfc_pkg::REG_WORDS_PER_FRAME;
        cfg_data <= '0;
        byte_ch.valid <= 1'b0;
        byte_ch.rx_byte <= '0;
        byte_ch.frame_start <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames of one word each.
        write_config(4'd1, 1'b1, 16'd40000);
        send_word(16'h0000, 1'b1, 1'b0);
        // Next frame begins by itself after the last word.
        send_word(16'hFFFF, 1'b0, 1'b0);
        send_word(16'd40000, 1'b0, 1'b0);
        send_word(16'd40001, 1'b0, 1'b0);
        // A zero first word with a bad CRC reports the CRC error.
        send_word(16'h0000, 1'b0, 1'b1);
        // A frame start in the middle of a group drops the partial group.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_word(16'h1234, 1'b1, 1'b0);
        wait_drained();
        // Zero frame length acts as one; a zero limit rejects any nonzero first word.
        write_config(4'd0, 1'b1, 16'd0);
        send_word(16'h0001, 1'b1, 1'b0);
        send_word(16'h0000, 1'b0, 1'b0);
        wait_drained();

        // Random phases, each under its own configuration.
        need_start = 1'b1;
        while (bytes_sent < BYTE_TARGET)
        begin
            case ($urandom_range(0, 5))
                0: words = 4'd0;
                1: words = 4'd1;
                2: words = 4'd8;
                3: words = 4'd15;
                default: words = 4'($urandom_range(0, 15));
            endcase
            check = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                0: limit = 16'd0;
                1: limit = 16'd1;
                2: limit = 16'd40000;
                3: limit = 16'hFFFF;
                default: limit = 16'($urandom);
            endcase
            write_config(words, check, limit);
            frame_len = (words == 4'd0) ? 1 : ((words > 4'd8) ? 8 : int'(words));
            phase_end = bytes_sent + $urandom_range(60, 200);
            while (bytes_sent < phase_end)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // Noise: random bytes with stray frame starts.
                        repeat ($urandom_range(1, 5))
                        begin
                            send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
                        end
                        need_start = 1'b1;
                    end
                    1:
                    begin
                        // A frame cut off before its last byte.
                        cut = $urandom_range(1, frame_len * 3 - 1);
                        for (int i = 0; i < cut; i++)
                        begin
                            send_byte(8'($urandom), (i == 0));
                        end
                        need_start = 1'b1;
                    end
                    default:
                    begin
                        for (int w = 0; w < frame_len; w++)
                        begin
                            send_word((w == 0) ? pick_first(limit) : 16'($urandom),
                                      (w == 0) && (need_start || $urandom_range(0, 1) == 1),
                                      ($urandom_range(0, 7) == 0));
                        end
                        need_start = 1'b0;
                    end
                endcase
            end
            wait_drained();
        end

        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: crc8_word_frame_checker.f
rtl/crc8wfc_pkg.sv
rtl/crc8wfc_if.sv
rtl/crc8wfc_cfg_regs.sv
rtl/crc8wfc_engine.sv
rtl/crc8_word_frame_checker.sv
test/crc8wfc_word_checker.sv
test/crc8_word_frame_checker_test.sv
